/* rtl/sefd_pkg.sv */
// ----------------------------------------------------------------------------
// sefd_pkg
// Shared types and constants for the start/length/end byte frame decoder.
// ----------------------------------------------------------------------------
package sefd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    // Reset values of the delimiter registers.
    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h03;

    // Register indexes, selected by paddr bit 2.
    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_END_BYTE   = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_GOOD  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] out_byte;
        logic [BYTE_W-1:0] frame_len;
    } t_result;

endpackage

/* rtl/stx_etx_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// stx_etx_frame_decoder_unit
// Decodes start, length, payload, XOR checksum, end byte frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_byte) carries one received
//   byte per word. Output channel (o_out_valid, i_out_stall, o_kind,
//   o_out_byte, o_frame_len) returns exactly one result word per input word:
//   nothing, a payload byte, frame good with its length, or frame error.
//   Payload bytes are only trustworthy once the frame reports good.
//   o_out_valid rises in the cycle after input acceptance. Throughput is
//   one byte per cycle unless the receiver stalls; the parse step is a
//   single compare, XOR and counter update between the parse state and the output register.
//   When the receiver stalls, the output register holds its word and
//   o_in_stall rises so no further byte is taken until the word leaves.
//   The APB port sets the start byte (address 0) and end byte (address 4);
//   write them only while the block is idle.
//   Reset clears the parser to idle, empties the output register and loads
//   the delimiters with 0x02 and 0x03.
// ----------------------------------------------------------------------------
module stx_etx_frame_decoder_unit
    import sefd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_kind,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic [BYTE_W-1:0] o_frame_len,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_in_accept;
    logic    r_out_valid, n_out_valid;
    t_result r_out;

    sefd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sefd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_accept),
        .i_byte   (i_in_byte),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign n_out_valid = w_in_accept || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out.kind;
    assign o_out_byte  = r_out.out_byte;
    assign o_frame_len = r_out.frame_len;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_out_valid)
        else $error("accepted byte produced no result word");

    a_byte_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_DATA |-> o_out_byte == '0)
        else $error("payload byte nonzero outside a data result");

    a_len_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_GOOD |-> o_frame_len == '0)
        else $error("frame length nonzero outside a good result");

endmodule

/* rtl/sefd_cfg.sv */
// ----------------------------------------------------------------------------
// sefd_cfg
// APB register file holding the start and end delimiter bytes.
// ----------------------------------------------------------------------------
module sefd_cfg
    import sefd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic              w_wr;
    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_end_byte;
    logic [BYTE_W-1:0] w_rd_byte;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_end_byte   <= END_BYTE_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_START_BYTE: r_start_byte <= pwdata[BYTE_W-1:0];
                REG_END_BYTE:   r_end_byte   <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_START_BYTE: w_rd_byte = r_start_byte;
            REG_END_BYTE:   w_rd_byte = r_end_byte;
            default:        w_rd_byte = r_start_byte;
        endcase
    end

    assign prdata           = {{(DATA_W-BYTE_W){1'b0}}, w_rd_byte};
    assign o_cfg.start_byte = r_start_byte;
    assign o_cfg.end_byte   = r_end_byte;

endmodule

/* rtl/sefd_parser.sv */
// ----------------------------------------------------------------------------
// sefd_parser
// Frame parse state machine: one byte per accepted word, one result each.
// ----------------------------------------------------------------------------
module sefd_parser
    import sefd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEN     = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CHK     = 3'd3,
        PH_END     = 3'd4,
        PH_DISCARD = 3'd5
    } t_phase;

    t_phase            r_phase,       n_phase;
    logic [BYTE_W-1:0] r_bytes_left,  n_bytes_left;
    logic [BYTE_W-1:0] r_payload_len, n_payload_len;
    logic [BYTE_W-1:0] r_running_xor, n_running_xor;
    logic [BYTE_W-1:0] w_left_dec;

    assign w_left_dec = r_bytes_left - 1'b1;

    always_comb begin
        n_phase            = r_phase;
        n_bytes_left       = r_bytes_left;
        n_payload_len      = r_payload_len;
        n_running_xor      = r_running_xor;
        o_result.kind      = KIND_NONE;
        o_result.out_byte  = '0;
        o_result.frame_len = '0;
        unique case (r_phase)
            PH_LEN: begin
                n_payload_len = i_byte;
                n_bytes_left  = i_byte;
                n_running_xor = '0;
                n_phase       = (i_byte == '0) ? PH_CHK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                o_result.kind     = KIND_DATA;
                o_result.out_byte = i_byte;
                n_running_xor     = r_running_xor ^ i_byte;
                n_bytes_left      = w_left_dec;
                if (w_left_dec == '0) begin
                    n_phase = PH_CHK;
                end
            end
            PH_CHK: begin
                // The checksum byte is never taken as an end byte.
                n_phase = (i_byte == r_running_xor) ? PH_END : PH_DISCARD;
            end
            PH_END: begin
                if (i_byte == i_cfg.end_byte) begin
                    o_result.kind      = KIND_GOOD;
                    o_result.frame_len = r_payload_len;
                    n_phase            = PH_IDLE;
                end else begin
                    n_phase = PH_DISCARD;
                end
            end
            PH_DISCARD: begin
                if (i_byte == i_cfg.end_byte) begin
                    o_result.kind = KIND_ERROR;
                    n_phase       = PH_IDLE;
                end
            end
            default: begin
                // Start byte wins over end byte when both registers match.
                if (i_byte == i_cfg.start_byte) begin
                    n_running_xor = '0;
                    n_phase       = PH_LEN;
                end else if (i_byte == i_cfg.end_byte) begin
                    o_result.kind = KIND_ERROR;
                    n_phase       = PH_IDLE;
                end else begin
                    n_phase = PH_DISCARD;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bytes_left  <= '0;
            r_payload_len <= '0;
            r_running_xor <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_bytes_left  <= n_bytes_left;
            r_payload_len <= n_payload_len;
            r_running_xor <= n_running_xor;
        end
    end

    a_empty_to_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_phase == PH_LEN && i_byte == '0 |=> r_phase == PH_CHK)
        else $error("empty payload did not go to checksum phase");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_bytes_left != '0)
        else $error("payload phase with no bytes left");

endmodule

/* bench/tb_stx_etx_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// tb_stx_etx_frame_decoder_unit
// Self-checking bench for the start/length/end byte frame decoder. A queue of
// received bytes feeds a bursty driver, and a clocked monitor compares every
// result word with a frame parser kept inside the bench. The delimiter
// registers are rewritten over the APB port between traffic phases.
// ----------------------------------------------------------------------------
module tb_stx_etx_frame_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sefd_pkg::*;

    localparam int unsigned CLK_PERIOD  = 4;
    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef enum logic [2:0] {
        S_HUNT,
        S_LENGTH,
        S_BODY,
        S_CHECK,
        S_TAIL,
        S_SKIP
    } t_parse_state;

    typedef enum int {
        FRAME_OK,
        FRAME_BAD_CHECK,
        FRAME_NO_END
    } t_defect;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [BYTE_W-1:0] i_in_byte   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_kind;
    logic [BYTE_W-1:0] o_out_byte;
    logic [BYTE_W-1:0] o_frame_len;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    stx_etx_frame_decoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_frame_len (o_frame_len),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Bytes waiting to be sent and decoder results waiting to be seen.
    logic [BYTE_W-1:0] rx_bytes[$];
    t_result           pending_results[$];

    // Frame parser state and the delimiters it currently uses.
    t_parse_state      parse_state = S_HUNT;
    logic [BYTE_W-1:0] bytes_due   = '0;
    logic [BYTE_W-1:0] len_field   = '0;
    logic [BYTE_W-1:0] xor_sum     = '0;
    logic [BYTE_W-1:0] start_delim = START_BYTE_RST;
    logic [BYTE_W-1:0] end_delim   = END_BYTE_RST;

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 1;
    int unsigned gap_left    = 0;
    int unsigned stall_mode  = 0;
    int unsigned stall_run   = 0;
    bit          byte_taken  = 1'b0;

    function automatic t_result parse_byte(input logic [BYTE_W-1:0] b);
        t_result res;
        res = '0;
        res.kind = KIND_NONE;
        case (parse_state)
            S_LENGTH: begin
                len_field   = b;
                bytes_due   = b;
                xor_sum     = '0;
                parse_state = (b == '0) ? S_CHECK : S_BODY;
            end
            S_BODY: begin
                res.kind     = KIND_DATA;
                res.out_byte = b;
                xor_sum      = xor_sum ^ b;
                bytes_due    = bytes_due - 1'b1;
                if (bytes_due == '0) begin
                    parse_state = S_CHECK;
                end
            end
            // The checksum byte is never taken as the end byte.
            S_CHECK: parse_state = (b == xor_sum) ? S_TAIL : S_SKIP;
            S_TAIL: begin
                if (b == end_delim) begin
                    res.kind      = KIND_GOOD;
                    res.frame_len = len_field;
                    parse_state   = S_HUNT;
                end else begin
                    parse_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (b == end_delim) begin
                    res.kind    = KIND_ERROR;
                    parse_state = S_HUNT;
                end
            end
            default: begin
                // The start byte wins when both delimiters are equal.
                if (b == start_delim) begin
                    xor_sum     = '0;
                    parse_state = S_LENGTH;
                end else if (b == end_delim) begin
                    res.kind    = KIND_ERROR;
                    parse_state = S_HUNT;
                end else begin
                    parse_state = S_SKIP;
                end
            end
        endcase
        return res;
    endfunction

    // Byte driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || byte_taken)) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (rx_bytes.size() != 0) begin
                i_in_byte  <= rx_bytes.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) == 0) begin
                        gap_left = 0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        gap_left = $urandom_range(4, 15);
                    end else begin
                        gap_left = $urandom_range(1, 3);
                    end
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: runs of free flow, light, medium and heavy back-pressure.
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(8, 60);
        end
        stall_run--;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            byte_taken = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no byte pending: kind %0d", o_kind);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, o_kind);
                        fail_count++;
                    end
                    if (o_out_byte !== want.out_byte) begin
                        $error("out_byte: expected 0x%02h, actual 0x%02h",
                               want.out_byte, o_out_byte);
                        fail_count++;
                    end
                    if (o_frame_len !== want.frame_len) begin
                        $error("frame_len: expected %0d, actual %0d",
                               want.frame_len, o_frame_len);
                        fail_count++;
                    end
                end
            end
            byte_taken = i_in_valid && !o_in_stall;
            if (byte_taken) begin
                pending_results.push_back(parse_byte(i_in_byte));
            end
        end
    end

    task automatic write_delim(input logic reg_sel, input logic [BYTE_W-1:0] value);
        logic [DATA_W-1:0] readback;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {24'($urandom_range(0, 16777215)), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == REG_START_BYTE) begin
            start_delim = value;
        end else begin
            end_delim = value;
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[BYTE_W-1:0] !== value) begin
            $error("prdata: expected 0x%02h, actual 0x%02h", value, readback[BYTE_W-1:0]);
            fail_count++;
        end
    endtask

    task automatic add_frame(input int unsigned len, input t_defect defect);
        logic [BYTE_W-1:0] chk;
        logic [BYTE_W-1:0] b;
        chk = '0;
        rx_bytes.push_back(start_delim);
        rx_bytes.push_back(len[BYTE_W-1:0]);
        repeat (len) begin
            b = BYTE_W'($urandom);
            chk ^= b;
            rx_bytes.push_back(b);
        end
        if (defect == FRAME_BAD_CHECK) begin
            chk ^= BYTE_W'($urandom_range(1, 255));
        end
        rx_bytes.push_back(chk);
        if (defect == FRAME_NO_END) begin
            do b = BYTE_W'($urandom); while (b == end_delim);
            rx_bytes.push_back(b);
        end
        rx_bytes.push_back(end_delim);
    endtask

    // Mostly well-formed frames with random payload, mixed with damaged frames and noise.
    task automatic add_traffic(input int unsigned n_bytes);
        int unsigned base;
        int unsigned pick;
        int unsigned len;
        base = rx_bytes.size();
        while (rx_bytes.size() - base < n_bytes) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            if (pick < 65) begin
                add_frame(len, FRAME_OK);
            end else if (pick < 75) begin
                add_frame(len, FRAME_BAD_CHECK);
            end else if (pick < 83) begin
                add_frame(len, FRAME_NO_END);
            end else begin
                repeat ($urandom_range(1, 6)) rx_bytes.push_back(BYTE_W'($urandom));
                rx_bytes.push_back(end_delim);
            end
        end
    endtask

    // Returns once every queued word has been taken and answered.
    task automatic drain();
        do @(posedge i_clk);
        while (rx_bytes.size() != 0 || i_in_valid || pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames with the reset delimiters.
        add_frame(0, FRAME_OK);
        // Payload holding both delimiter values.
        rx_bytes.push_back(start_delim);
        rx_bytes.push_back(8'd2);
        rx_bytes.push_back(8'h03);
        rx_bytes.push_back(8'h02);
        rx_bytes.push_back(8'h01);
        rx_bytes.push_back(end_delim);
        // Bad start byte, then the end byte closes the discard.
        rx_bytes.push_back(8'hFF);
        rx_bytes.push_back(end_delim);
        // A lone end byte while hunting reports an error at once.
        rx_bytes.push_back(end_delim);
        // Wrong checksum equal to the end byte must not close the frame.
        rx_bytes.push_back(start_delim);
        rx_bytes.push_back(8'd1);
        rx_bytes.push_back(8'hAA);
        rx_bytes.push_back(end_delim);
        rx_bytes.push_back(end_delim);
        // Empty frame whose end byte is missing.
        rx_bytes.push_back(start_delim);
        rx_bytes.push_back(8'd0);
        rx_bytes.push_back(8'd0);
        rx_bytes.push_back(8'h55);
        rx_bytes.push_back(end_delim);
        add_traffic(90);
        drain();

        write_delim(REG_START_BYTE, 8'h00);
        write_delim(REG_END_BYTE, 8'hFF);
        add_traffic(30);
        add_frame(255, FRAME_OK);
        add_traffic(40);
        drain();

        write_delim(REG_START_BYTE, 8'hFF);
        write_delim(REG_END_BYTE, 8'h00);
        add_traffic(70);
        drain();

        // Equal delimiters: a start byte while hunting opens a frame.
        write_delim(REG_END_BYTE, 8'h7E);
        write_delim(REG_START_BYTE, 8'h7E);
        add_traffic(50);
        drain();

        write_delim(REG_START_BYTE, BYTE_W'($urandom));
        write_delim(REG_END_BYTE, BYTE_W'($urandom));
        add_traffic(50);
        drain();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/sefd_pkg.sv
rtl/sefd_cfg.sv
rtl/sefd_parser.sv
rtl/stx_etx_frame_decoder_unit.sv
bench/tb_stx_etx_frame_decoder_unit.sv
